FILE: rtl/ffaa_pkg.sv
`timescale 1ns / 1ps

package ffaa_pkg;

	localparam int ARENA_BYTES_DEF  = 4096;
	localparam int HEADER_BYTES_DEF = 32;
	localparam int MAX_BLOCKS_DEF   = 128;

	localparam int REQ_W    = 13;
	localparam int STATUS_W = 3;
	localparam int PADDR_W  = 12;

	localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STS_NO_ROOM   = 3'd1;
	localparam logic [STATUS_W-1:0] STS_DBL_FREE  = 3'd2;
	localparam logic [STATUS_W-1:0] STS_NOT_START = 3'd3;
	localparam logic [STATUS_W-1:0] STS_RANGE     = 3'd4;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_LOAD,
		ST_A_EVAL,
		ST_UP_PRIME,
		ST_UP,
		ST_INS_PUT,
		ST_F_SCAN,
		ST_F_NEXT,
		ST_DN_PRIME,
		ST_DN,
		ST_FIN
	} state_t;

endpackage

FILE: rtl/first_fit_arena_allocator_unit.sv
`timescale 1ns / 1ps
// channel | handshake            | payload
// in      | in_valid / in_stall   | func, req_size, free_addr
// out     | out_valid / out_stall | status, payload_addr
//
// One request at a time. An allocate walks the table first-fit, one table entry per cycle
// through the single read port. A new block that follows a used block is inserted:
// mid-table the entries after it are first shifted up one per cycle, and after the
// last block it is simply appended. A free searches the table for the block, then
// writes the freed entry, merged with free neighbors; when neighbors merge, the entries
// behind them are moved down one per cycle.
// A finished result waits in the output register while the next request is taken.
// arst_n clears the block count; the table needs no clear.
module first_fit_arena_allocator_unit #(
	parameter int ARENA_BYTES  = ffaa_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = ffaa_pkg::HEADER_BYTES_DEF,
	parameter int MAX_BLOCKS   = ffaa_pkg::MAX_BLOCKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic [ffaa_pkg::REQ_W-1:0]     req_size,
	input  logic [ffaa_pkg::REQ_W-1:0]     free_addr,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ffaa_pkg::STATUS_W-1:0]  status,
	output logic [ffaa_pkg::PADDR_W-1:0]   payload_addr
);

	localparam int AW  = $clog2(ARENA_BYTES + 1);
	localparam int XW  = ((AW + 2) > (ffaa_pkg::REQ_W + 1)) ? (AW + 2) : (ffaa_pkg::REQ_W + 1);
	localparam int EW  = 2 * AW + 1;
	localparam int IW  = $clog2(MAX_BLOCKS);
	localparam int CNW = $clog2(MAX_BLOCKS + 1);

	localparam logic [XW-1:0]  HDR   = XW'(HEADER_BYTES);
	localparam logic [XW-1:0]  ARENA = XW'(ARENA_BYTES);
	localparam logic [CNW-1:0] MAXB  = CNW'(MAX_BLOCKS);
	localparam logic [CNW-1:0] ONE   = CNW'(1);

	logic [EW-1:0] mem [MAX_BLOCKS];

	ffaa_pkg::state_t state_q, state_d;

	logic [EW-1:0]  rd_q;
	logic [CNW-1:0] count_q, idx_q, j_q, pos_q;
	logic           two_q;
	logic [XW-1:0]  req_q, addr_q;
	logic [AW-1:0]  cur_start_q, cur_size_q, prev_start_q, prev_size_q;
	logic           cur_free_q, prev_free_q;
	logic [AW-1:0]  new_start_q, new_size_q;
	logic [ffaa_pkg::STATUS_W-1:0] res_status_q, status_q;
	logic [ffaa_pkg::PADDR_W-1:0]  res_addr_q, paddr_q;
	logic           out_valid_q;

	logic [IW-1:0]  raddr, waddr;
	logic [CNW:0]   raddr_w;
	logic           we;
	logic [EW-1:0]  wdata;

	logic [AW-1:0]  rd_start, rd_size;
	logic           rd_free;
	assign rd_start = rd_q[AW-1:0];
	assign rd_size  = rd_q[2*AW-1:AW];
	assign rd_free  = rd_q[EW-1];

	logic [XW-1:0] in_req, in_addr;
	assign in_req  = XW'(req_size);
	assign in_addr = XW'(free_addr);

	logic accept, bad_size, bad_addr;
	assign accept   = in_valid && !in_stall;
	assign bad_size = (in_req == '0) || (in_req + HDR > ARENA);
	assign bad_addr = (in_addr < HDR) || (in_addr >= ARENA);

	// walk evaluation of entry idx (cur) against its successor (rd)
	logic          last;
	logic [XW-1:0] limit, pay, blk_end;
	logic          free_fit, used_fit, tbl_full;
	assign last     = (idx_q + ONE == count_q);
	assign limit    = last ? ARENA : XW'(rd_start);
	assign pay      = XW'(cur_start_q) + HDR;
	assign blk_end  = pay + XW'(cur_size_q);
	assign free_fit = cur_free_q && (limit >= pay) && (limit - pay >= req_q);
	assign used_fit = !cur_free_q && (limit >= blk_end) && (limit - blk_end >= HDR + req_q);
	assign tbl_full = (count_q >= MAXB);

	// free search and merge
	logic scan_hit, scan_last, prev_m, next_m;
	assign scan_hit  = (XW'(rd_start) + HDR == addr_q);
	assign scan_last = (idx_q + ONE == count_q);
	assign prev_m    = (idx_q != '0) && prev_free_q;
	assign next_m    = (idx_q + ONE < count_q) && rd_free;

	logic [XW-1:0] next_add;
	assign next_add = next_m ? (XW'(rd_size) + HDR) : '0;

	logic fin_go;
	assign fin_go = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffaa_pkg::ST_IDLE: begin
				if (accept) begin
					if (func == ffaa_pkg::FUNC_ALLOC) begin
						if (bad_size || count_q == '0)
							state_d = ffaa_pkg::ST_FIN;
						else
							state_d = ffaa_pkg::ST_A_LOAD;
					end else begin
						if (bad_addr || count_q == '0)
							state_d = ffaa_pkg::ST_FIN;
						else
							state_d = ffaa_pkg::ST_F_SCAN;
					end
				end
			end
			ffaa_pkg::ST_A_LOAD: state_d = ffaa_pkg::ST_A_EVAL;
			ffaa_pkg::ST_A_EVAL: begin
				if (free_fit)
					state_d = ffaa_pkg::ST_FIN;
				else if (used_fit) begin
					if (tbl_full)
						state_d = ffaa_pkg::ST_FIN;
					else if (last)
						state_d = ffaa_pkg::ST_INS_PUT;
					else
						state_d = ffaa_pkg::ST_UP_PRIME;
				end else if (last)
					state_d = ffaa_pkg::ST_FIN;
			end
			ffaa_pkg::ST_UP_PRIME: state_d = ffaa_pkg::ST_UP;
			ffaa_pkg::ST_UP: begin
				if (j_q == pos_q)
					state_d = ffaa_pkg::ST_INS_PUT;
			end
			ffaa_pkg::ST_INS_PUT: state_d = ffaa_pkg::ST_FIN;
			ffaa_pkg::ST_F_SCAN: begin
				if (scan_hit)
					state_d = rd_free ? ffaa_pkg::ST_FIN : ffaa_pkg::ST_F_NEXT;
				else if (scan_last)
					state_d = ffaa_pkg::ST_FIN;
			end
			ffaa_pkg::ST_F_NEXT: begin
				if (prev_m || next_m)
					state_d = ffaa_pkg::ST_DN_PRIME;
				else
					state_d = ffaa_pkg::ST_FIN;
			end
			ffaa_pkg::ST_DN_PRIME: begin
				if (j_q >= count_q)
					state_d = ffaa_pkg::ST_FIN;
				else
					state_d = ffaa_pkg::ST_DN;
			end
			ffaa_pkg::ST_DN: begin
				if (j_q + ONE == count_q)
					state_d = ffaa_pkg::ST_FIN;
			end
			ffaa_pkg::ST_FIN: begin
				if (fin_go)
					state_d = ffaa_pkg::ST_IDLE;
			end
			default: state_d = ffaa_pkg::ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		raddr_w = '0;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		case (state_q)
			ffaa_pkg::ST_IDLE: begin
				if (accept && func == ffaa_pkg::FUNC_ALLOC && !bad_size && count_q == '0) begin
					we    = 1'b1;
					wdata = {1'b0, AW'(in_req), {AW{1'b0}}};
				end
			end
			ffaa_pkg::ST_A_LOAD: raddr_w = (CNW + 1)'(idx_q) + 1'b1;
			ffaa_pkg::ST_A_EVAL: begin
				raddr_w = (CNW + 1)'(idx_q) + 2'd2;
				if (free_fit) begin
					we    = 1'b1;
					waddr = idx_q[IW-1:0];
					wdata = {1'b0, AW'(req_q), cur_start_q};
				end
			end
			ffaa_pkg::ST_UP_PRIME: raddr_w = (CNW + 1)'(j_q);
			ffaa_pkg::ST_UP: begin
				raddr_w = (CNW + 1)'(j_q) - 1'b1;
				we      = 1'b1;
				waddr   = IW'((CNW + 1)'(j_q) + 1'b1);
				wdata   = rd_q;
			end
			ffaa_pkg::ST_INS_PUT: begin
				we    = 1'b1;
				waddr = pos_q[IW-1:0];
				wdata = {1'b0, new_size_q, new_start_q};
			end
			ffaa_pkg::ST_F_SCAN: raddr_w = (CNW + 1)'(idx_q) + 1'b1;
			ffaa_pkg::ST_F_NEXT: begin
				we = 1'b1;
				if (prev_m) begin
					waddr = IW'(idx_q - ONE);
					wdata = {1'b1, AW'(XW'(prev_size_q) + XW'(cur_size_q) + HDR + next_add),
						prev_start_q};
				end else begin
					waddr = idx_q[IW-1:0];
					wdata = {1'b1, AW'(XW'(cur_size_q) + next_add), cur_start_q};
				end
			end
			ffaa_pkg::ST_DN_PRIME: raddr_w = (CNW + 1)'(j_q);
			ffaa_pkg::ST_DN: begin
				raddr_w = (CNW + 1)'(j_q) + 1'b1;
				we      = 1'b1;
				waddr   = IW'((CNW + 1)'(j_q) - (two_q ? 2'd2 : 2'd1));
				wdata   = rd_q;
			end
			default: ;
		endcase
	end
	assign raddr = raddr_w[IW-1:0];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffaa_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ffaa_pkg::ST_FIN && fin_go)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ffaa_pkg::ST_IDLE:
					if (accept && func == ffaa_pkg::FUNC_ALLOC && !bad_size && count_q == '0)
						count_q <= ONE;
				ffaa_pkg::ST_INS_PUT: count_q <= count_q + ONE;
				ffaa_pkg::ST_DN_PRIME:
					if (j_q >= count_q)
						count_q <= count_q - (two_q ? CNW'(2) : ONE);
				ffaa_pkg::ST_DN:
					if (j_q + ONE == count_q)
						count_q <= count_q - (two_q ? CNW'(2) : ONE);
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ffaa_pkg::ST_IDLE: begin
				idx_q  <= '0;
				req_q  <= in_req;
				addr_q <= in_addr;
				if (func == ffaa_pkg::FUNC_ALLOC) begin
					res_status_q <= bad_size ? ffaa_pkg::STS_NO_ROOM : ffaa_pkg::STS_OK;
					res_addr_q   <= bad_size ? '0 : ffaa_pkg::PADDR_W'(HDR);
				end else begin
					res_status_q <= bad_addr ? ffaa_pkg::STS_RANGE : ffaa_pkg::STS_NOT_START;
					res_addr_q   <= '0;
				end
			end
			ffaa_pkg::ST_A_LOAD: begin
				cur_start_q <= rd_start;
				cur_size_q  <= rd_size;
				cur_free_q  <= rd_free;
			end
			ffaa_pkg::ST_A_EVAL: begin
				if (free_fit) begin
					res_status_q <= ffaa_pkg::STS_OK;
					res_addr_q   <= ffaa_pkg::PADDR_W'(pay);
				end else if (used_fit) begin
					pos_q       <= idx_q + ONE;
					j_q         <= count_q - ONE;
					new_start_q <= AW'(blk_end);
					new_size_q  <= AW'(req_q);
					if (tbl_full) begin
						res_status_q <= ffaa_pkg::STS_NO_ROOM;
						res_addr_q   <= '0;
					end else begin
						res_status_q <= ffaa_pkg::STS_OK;
						res_addr_q   <= ffaa_pkg::PADDR_W'(blk_end + HDR);
					end
				end else if (last) begin
					res_status_q <= ffaa_pkg::STS_NO_ROOM;
					res_addr_q   <= '0;
				end else begin
					idx_q       <= idx_q + ONE;
					cur_start_q <= rd_start;
					cur_size_q  <= rd_size;
					cur_free_q  <= rd_free;
				end
			end
			ffaa_pkg::ST_UP: j_q <= j_q - ONE;
			ffaa_pkg::ST_F_SCAN: begin
				if (scan_hit) begin
					cur_start_q <= rd_start;
					cur_size_q  <= rd_size;
					cur_free_q  <= rd_free;
					res_status_q <= rd_free ? ffaa_pkg::STS_DBL_FREE : ffaa_pkg::STS_OK;
				end else begin
					prev_start_q <= rd_start;
					prev_size_q  <= rd_size;
					prev_free_q  <= rd_free;
					idx_q        <= idx_q + ONE;
				end
			end
			ffaa_pkg::ST_F_NEXT: begin
				two_q <= prev_m && next_m;
				if (prev_m) begin
					pos_q <= idx_q;
					j_q   <= idx_q + (next_m ? CNW'(2) : ONE);
				end else begin
					pos_q <= idx_q + ONE;
					j_q   <= idx_q + CNW'(2);
				end
			end
			ffaa_pkg::ST_DN: j_q <= j_q + ONE;
			ffaa_pkg::ST_FIN:
				if (fin_go) begin
					status_q <= res_status_q;
					paddr_q  <= res_addr_q;
				end
			default: ;
		endcase
	end

	assign in_stall     = (state_q != ffaa_pkg::ST_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign payload_addr = paddr_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAXB)
		else $error("block count beyond table depth");

	a_up_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffaa_pkg::ST_UP |-> (j_q >= pos_q && j_q < count_q))
		else $error("shift-up index out of range");

	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ffaa_pkg::STS_OK |-> paddr_q == '0)
		else $error("failed request carries an address");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffaa_pkg::ST_INS_PUT |-> count_q < MAXB)
		else $error("insert into full table");
`endif

endmodule
